[hw/rtl/elfh_pkg.sv]
`default_nettype none

package elfh_pkg;

    localparam int WordW    = 32;
    localparam int HashW    = 28;
    localparam int ByteW    = 8;
    localparam int CntW     = $clog2(HashW);
    localparam int StepShift = 4;
    localparam int FoldShift = 24;

    localparam logic [WordW-1:0] TopNibble     = 32'hF000_0000;
    localparam logic [WordW-1:0] TableSizeRst  = 32'hFFFF_FFFF;
    localparam logic [CntW-1:0]  LastCnt       = CntW'(HashW - 1);
    localparam logic [ByteW-1:0] Terminator    = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } elfh_state_t;

    // One step of the ELF hash: shift in a byte, fold the top nibble into bits 7..4.
    function automatic logic [HashW-1:0] elf_update(
        input logic [HashW-1:0] h,
        input logic [ByteW-1:0] b
    );
        logic [WordW-1:0] t;
        logic [WordW-1:0] top;
        t   = {h, {StepShift{1'b0}}} + {{(WordW-ByteW){1'b0}}, b};
        top = t & TopNibble;
        t   = t ^ (top >> FoldShift);
        t   = t & ~top;
        return t[HashW-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/elfh_div_unit.sv]
`default_nettype none

module elfh_div_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [elfh_pkg::HashW-1:0] dividend,
    input  wire logic [elfh_pkg::WordW-1:0] divisor,
    output logic                           done,
    output logic [elfh_pkg::HashW-1:0]     remainder
);
    import elfh_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [HashW-1:0]  quo_reg, quo_next;
    logic [HashW-1:0]  rem_reg, rem_next;
    logic [HashW:0]    trial;
    logic [HashW:0]    diff;
    logic              fits;

    // One restoring step per cycle; a zero divisor leaves the dividend itself.
    assign trial = {rem_reg, quo_reg[HashW-1]};
    assign fits  = {{(WordW-HashW-1){1'b0}}, trial} >= divisor;
    assign diff  = trial - divisor[HashW:0];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = LastCnt;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[HashW-2:0], 1'b0};
            rem_next = fits ? diff[HashW-1:0] : trial[HashW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/elf_string_hash_mod.sv]
// Channel  Direction  Handshake                Payload
// input    in         in_valid / in_stall      char_byte
// output   out        out_valid / out_stall    bucket_index, raw_hash
// config   in         cfg_we                   cfg_wdata (table_size)
//
// A nonzero byte word is hashed in and the next byte is taken at once.
// A zero byte word starts the restoring divider, one remainder bit per cycle;
// the result word enters the output register once the division ends and
// the output register is free; the next byte can be taken in the cycle after.
// Bytes are still taken while a result word waits on out_stall.
// Reset clears the running hash and sets table_size to all ones.
`default_nettype none

module elf_string_hash_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [elfh_pkg::WordW-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [elfh_pkg::ByteW-1:0] char_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [elfh_pkg::WordW-1:0]      bucket_index,
    output logic [elfh_pkg::HashW-1:0]      raw_hash
);
    import elfh_pkg::*;

    elfh_state_t       state_reg, state_next;
    logic [WordW-1:0]  table_size_reg;
    logic [HashW-1:0]  hash_reg, hash_next;
    logic [HashW-1:0]  final_reg, final_next;
    logic              out_valid_reg, out_valid_next;
    logic [WordW-1:0]  bucket_reg, bucket_next;
    logic [HashW-1:0]  raw_reg, raw_next;
    logic              in_fire;
    logic              div_start;
    logic              div_done;
    logic [HashW-1:0]  div_rem;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    elfh_div_unit u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (hash_reg),
        .divisor   (table_size_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && out_stall;
        bucket_next    = bucket_reg;
        raw_next       = raw_reg;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (char_byte != Terminator)
                    begin
                        hash_next = elf_update(hash_reg, char_byte);
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        final_next = hash_reg;
                        hash_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    bucket_next    = {{(WordW-HashW){1'b0}}, div_rem};
                    raw_next       = final_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hash_reg       <= '0;
            out_valid_reg  <= 1'b0;
            table_size_reg <= TableSizeRst;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        final_reg  <= final_next;
        bucket_reg <= bucket_next;
        raw_reg    <= raw_next;
    end

    assign out_valid    = out_valid_reg;
    assign bucket_index = bucket_reg;
    assign raw_hash     = raw_reg;

`ifndef SYNTH
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result word appeared without a finished division");

    a_bucket_le_hash: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bucket_index <= {{(WordW-HashW){1'b0}}, raw_hash})
        else $error("bucket index exceeds raw hash");

    a_bucket_lt_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_size_reg != '0) |-> bucket_index < table_size_reg)
        else $error("bucket index not below table size");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire
